// ===== hw/rtl/rfbs_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and the channel filter bandwidth table of the
// receive filter bandwidth selector. No dependencies.
package rfbs_pkg;

   // Crystal frequency in Hz and derived arithmetic widths.
   localparam logic [24:0] XtalHz    = 25'd26000000;
   localparam int          RateProdW = 34;   // (256 + mantissa) * crystal
   localparam int          DevProdW  = 29;   // (8 + mantissa) * crystal
   localparam int          RateHzW   = 21;
   localparam int          DevHzW    = 19;
   localparam int          BwHzW     = 20;
   localparam int          GuardW    = 20;
   localparam int          NeedW     = 22;

   // Modulation format codes, bits 6:4 of the modem config register.
   localparam logic [2:0] MOD_2FSK = 3'd0;
   localparam logic [2:0] MOD_GFSK = 3'd1;
   localparam logic [2:0] MOD_OOK  = 3'd3;

   // Fixed register patches.
   localparam logic [3:0]       OOK_BW_CODE       = 4'hA;
   localparam logic [2:0]       AGC_NARROW_LOW    = 3'd3;
   localparam logic [BwHzW-1:0] AGC_NARROW_LIMIT  = 20'd101562;
   localparam logic [GuardW-1:0] GUARD_RESET      = 20'd50000;

   typedef enum logic [1:0] {
      ACT_RETAIN      = 2'd0,
      ACT_FM_OK       = 2'd1,
      ACT_FM_NARROWED = 2'd2,
      ACT_OOK         = 2'd3
   } action_type;

   // One input item: the register values and their present flags.
   typedef struct packed {
      logic [7:0] modcfg_value;
      logic       modcfg_present;
      logic [7:0] rate_mantissa_value;
      logic       rate_mantissa_present;
      logic [7:0] bw_exp_value;
      logic       bw_exp_present;
      logic [7:0] deviation_value;
      logic       deviation_present;
      logic [7:0] agc_value;
      logic       agc_present;
   } regs_type;

   // Item after the data rate and deviation have been worked out.
   typedef struct packed {
      regs_type             regs;
      logic [RateHzW-1:0]   rate_hz;
      logic [DevHzW-1:0]    dev_hz;
   } freq_type;

   // One result item.
   typedef struct packed {
      action_type          action;
      logic [7:0]          new_bw_exp;
      logic [7:0]          new_agc;
      logic                agc_changed;
      logic [BwHzW-1:0]    bandwidth_hz;
   } result_type;

   // Channel filter bandwidth of a 4-bit bandwidth code (exponent 3:2,
   // mantissa 1:0): crystal / (8 * (4 + M) * 2^E), truncated.
   function automatic logic [BwHzW-1:0] chan_bw(input logic [3:0] code);
      logic [BwHzW-1:0] hz;
      case (code)
         4'd0:    hz = 20'd812500;
         4'd1:    hz = 20'd650000;
         4'd2:    hz = 20'd541666;
         4'd3:    hz = 20'd464285;
         4'd4:    hz = 20'd406250;
         4'd5:    hz = 20'd325000;
         4'd6:    hz = 20'd270833;
         4'd7:    hz = 20'd232142;
         4'd8:    hz = 20'd203125;
         4'd9:    hz = 20'd162500;
         4'd10:   hz = 20'd135416;
         4'd11:   hz = 20'd116071;
         4'd12:   hz = 20'd101562;
         4'd13:   hz = 20'd81250;
         4'd14:   hz = 20'd67708;
         default: hz = 20'd58035;
      endcase
      return hz;
   endfunction

endpackage

// ===== hw/rtl/rfbs_freq_calc.sv =====
`timescale 1ns / 1ps
// Two pipeline stages that turn the rate and deviation registers into Hz.
// Depends on rfbs_pkg.
module rfbs_freq_calc (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  rfbs_pkg::regs_type in_regs,
   output logic               out_valid,
   input  logic               out_ready,
   output rfbs_pkg::freq_type out_freq
);
   import rfbs_pkg::*;

   logic                 s1_valid_ff;
   regs_type             s1_regs_ff;
   logic [RateProdW-1:0] s1_rate_prod_ff;
   logic [RateProdW-1:0] s1_rate_prod_in;
   logic [DevProdW-1:0]  s1_dev_prod_ff;
   logic [DevProdW-1:0]  s1_dev_prod_in;
   logic                 s1_adv;

   logic                 s2_valid_ff;
   freq_type             s2_freq_ff;
   freq_type             s2_freq_in;
   logic                 s2_adv;

   logic [RateProdW+14:0] rate_shifted;
   logic [RateProdW+14:0] rate_rounded;
   logic [DevProdW+6:0]   dev_shifted;
   logic [DevProdW+6:0]   dev_rounded;

   // A stage takes a new item when it is empty or its item moves on.
   assign s2_adv   = !s2_valid_ff || out_ready;
   assign s1_adv   = !s1_valid_ff || s2_adv;
   assign in_ready = s1_adv;

   // Stage 1: constant multiplies of the mantissas by the crystal frequency.
   always_comb begin
      s1_rate_prod_in = RateProdW'({1'b1, in_regs.rate_mantissa_value})
                        * RateProdW'(XtalHz);
      s1_dev_prod_in  = DevProdW'({1'b1, in_regs.deviation_value[2:0]})
                        * DevProdW'(XtalHz);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         s1_valid_ff <= in_valid;
      end
      if (s1_adv && in_valid) begin
         s1_regs_ff      <= in_regs;
         s1_rate_prod_ff <= s1_rate_prod_in;
         s1_dev_prod_ff  <= s1_dev_prod_in;
      end
   end

   // Stage 2: apply the exponents, round to the nearest Hz and scale down.
   always_comb begin
      rate_shifted = (RateProdW+15)'(s1_rate_prod_ff) << s1_regs_ff.bw_exp_value[3:0];
      rate_rounded = rate_shifted + ((RateProdW+15)'(1) << 27);
      dev_shifted  = (DevProdW+7)'(s1_dev_prod_ff) << s1_regs_ff.deviation_value[6:4];
      dev_rounded  = dev_shifted + ((DevProdW+7)'(1) << 16);
      s2_freq_in.regs    = s1_regs_ff;
      s2_freq_in.rate_hz = rate_rounded[RateProdW+14:28];
      s2_freq_in.dev_hz  = dev_rounded[DevProdW+6:17];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (s2_adv && s1_valid_ff) begin
         s2_freq_ff <= s2_freq_in;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_freq  = s2_freq_ff;

   // A held item must not be overwritten while the next stage refuses it.
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff && !out_ready |=> s2_valid_ff && $stable(s2_freq_ff))
      else $error("rfbs_freq_calc: blocked item changed");

   // The deviation of the widest setting stays inside its field.
   a_dev_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> s2_freq_ff.dev_hz <= DevHzW'(380859))
      else $error("rfbs_freq_calc: deviation out of range");

   // Stage 1 only fills when an item is offered.
   a_fill_source: assert property (@(posedge clock) disable iff (reset)
      !s1_valid_ff && !in_valid |=> !s1_valid_ff)
      else $error("rfbs_freq_calc: stage filled without an item");

endmodule

// ===== hw/rtl/rfbs_bw_select.sv =====
`timescale 1ns / 1ps
// Two pipeline stages: bandwidth need, then filter choice and register patch.
// Depends on rfbs_pkg.
module rfbs_bw_select (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [rfbs_pkg::GuardW-1:0]  guard_hz,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  rfbs_pkg::freq_type           in_freq,
   output logic                         out_valid,
   input  logic                         out_ready,
   output rfbs_pkg::result_type         out_result
);
   import rfbs_pkg::*;

   logic             s3_valid_ff;
   regs_type         s3_regs_ff;
   logic [NeedW-1:0] s3_need_ff;
   logic [NeedW-1:0] s3_need_in;
   logic             s3_adv;

   logic             s4_valid_ff;
   result_type       s4_result_ff;
   result_type       s4_result_in;
   logic             s4_adv;

   logic [15:0]      fits;
   logic [4:0]       fit_count;
   logic [3:0]       sel_code;
   logic [BwHzW-1:0] sel_hz;
   logic [BwHzW-1:0] orig_hz;
   logic [2:0]       fmt;

   assign s4_adv   = !s4_valid_ff || out_ready;
   assign s3_adv   = !s3_valid_ff || s4_adv;
   assign in_ready = s3_adv;

   // Stage 3: bandwidth the FM signal needs, with the guard margin.
   assign s3_need_in = NeedW'(in_freq.rate_hz) + NeedW'({in_freq.dev_hz, 1'b0})
                       + NeedW'(guard_hz);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_adv) begin
         s3_valid_ff <= in_valid;
      end
      if (s3_adv && in_valid) begin
         s3_regs_ff <= in_freq.regs;
         s3_need_ff <= s3_need_in;
      end
   end

   // Stage 4: the table falls with the code, so the settings that meet the
   // need form a run from code 0 and the narrowest is the last of them.
   always_comb begin
      for (int i = 0; i < 16; i++) begin
         fits[i] = NeedW'(chan_bw(4'(i))) >= s3_need_ff;
      end
      fit_count = 5'($countones(fits));
      sel_code  = (fit_count == 5'd0) ? 4'd0 : 4'(fit_count - 5'd1);
      sel_hz    = chan_bw(sel_code);
      orig_hz   = chan_bw(s3_regs_ff.bw_exp_value[7:4]);
      fmt       = s3_regs_ff.modcfg_value[6:4];
   end

   // Stage 4: pick the action and patch the registers.
   always_comb begin
      s4_result_in.action       = ACT_RETAIN;
      s4_result_in.new_bw_exp   = s3_regs_ff.bw_exp_value;
      s4_result_in.new_agc      = s3_regs_ff.agc_value;
      s4_result_in.agc_changed  = 1'b0;
      s4_result_in.bandwidth_hz = s3_regs_ff.bw_exp_present ? orig_hz : '0;
      if (s3_regs_ff.modcfg_present) begin
         unique case (fmt) inside
            MOD_OOK: begin
               if (s3_regs_ff.bw_exp_present) begin
                  s4_result_in.action       = ACT_OOK;
                  s4_result_in.new_bw_exp   = {OOK_BW_CODE, s3_regs_ff.bw_exp_value[3:0]};
                  s4_result_in.bandwidth_hz = chan_bw(OOK_BW_CODE);
               end
            end
            MOD_2FSK, MOD_GFSK: begin
               if (s3_regs_ff.rate_mantissa_present && s3_regs_ff.bw_exp_present
                   && s3_regs_ff.deviation_present) begin
                  if (sel_hz >= orig_hz) begin
                     s4_result_in.action       = ACT_FM_OK;
                     s4_result_in.bandwidth_hz = orig_hz;
                  end else begin
                     s4_result_in.action       = ACT_FM_NARROWED;
                     s4_result_in.new_bw_exp   = {sel_code, s3_regs_ff.bw_exp_value[3:0]};
                     s4_result_in.bandwidth_hz = sel_hz;
                     if (sel_hz <= AGC_NARROW_LIMIT && s3_regs_ff.agc_present) begin
                        s4_result_in.new_agc     = {s3_regs_ff.agc_value[7:3], AGC_NARROW_LOW};
                        s4_result_in.agc_changed = 1'b1;
                     end
                  end
               end
            end
            default: begin
               s4_result_in.action = ACT_RETAIN;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s4_valid_ff <= 1'b0;
      end else if (s4_adv) begin
         s4_valid_ff <= s3_valid_ff;
      end
      if (s4_adv && s3_valid_ff) begin
         s4_result_ff <= s4_result_in;
      end
   end

   assign out_valid  = s4_valid_ff;
   assign out_result = s4_result_ff;

   // Whenever some setting meets the need, the chosen filter is wide enough for it.
   a_narrow_meets_need: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && fit_count != 5'd0 |-> NeedW'(sel_hz) >= s3_need_ff)
      else $error("rfbs_bw_select: chosen filter too narrow");

   // The matching settings form a contiguous run starting at code 0.
   a_thermometer: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff |-> ((fits + 16'd1) & fits) == 16'd0)
      else $error("rfbs_bw_select: fit mask not contiguous");

   // A result waiting on a stalled output stays put.
   a_hold_when_blocked: assert property (@(posedge clock) disable iff (reset)
      s4_valid_ff && !out_ready |=> s4_valid_ff && $stable(s4_result_ff))
      else $error("rfbs_bw_select: blocked result changed");

endmodule

// ===== hw/rtl/rx_filter_bandwidth_selector_core.sv =====
`timescale 1ns / 1ps
// Top level of the receive filter bandwidth selector: guard register and the
// four-stage pipeline. Depends on rfbs_pkg, rfbs_freq_calc and rfbs_bw_select.
//
// Usage:
//   An item on the req_ channel carries the modem register values, each with a
//   present flag. It is taken at a clock edge with req_valid high and
//   req_stall low. One result item per input item leaves on the rsp_ channel
//   and is taken at an edge with rsp_valid high and rsp_stall low.
//   The csr_ channel writes the guard margin (Hz) added to the FM bandwidth
//   need; csr_ready is always high. Write it only while no item is in flight.
//   The pipeline has four register stages: two for the data rate and
//   deviation multiplies and rounding, one for the need sum, and one for the
//   table compare and register patch, which is also the output register.
//   rsp_valid comes from that output register, which an item reaches after
//   the other three. Throughput is one item per cycle while rsp_stall is low.
//   When the receiver stalls, the held result stays stable and empty stages
//   behind it still fill, so up to four items are taken before req_stall
//   rises. Synchronous reset empties the pipeline and sets the guard to
//   50000 Hz.
module rx_filter_bandwidth_selector_core (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_modcfg_value,
   input  logic        req_modcfg_present,
   input  logic [7:0]  req_rate_mantissa_value,
   input  logic        req_rate_mantissa_present,
   input  logic [7:0]  req_bw_exp_value,
   input  logic        req_bw_exp_present,
   input  logic [7:0]  req_deviation_value,
   input  logic        req_deviation_present,
   input  logic [7:0]  req_agc_value,
   input  logic        req_agc_present,
   // Result items.
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_action,
   output logic [7:0]  rsp_new_bw_exp,
   output logic [7:0]  rsp_new_agc,
   output logic        rsp_agc_changed,
   output logic [19:0] rsp_bandwidth_hz,
   // Guard margin register.
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [19:0] csr_guard_hz
);
   import rfbs_pkg::*;

   logic [GuardW-1:0] guard_hz_ff;
   regs_type          req_regs;
   freq_type          calc_freq;
   logic              calc_valid;
   logic              calc_ready;
   logic              sel_in_ready;
   result_type        sel_result;
   logic              calc_in_ready;

   // Guard margin register; always ready.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         guard_hz_ff <= GUARD_RESET;
      end else if (csr_valid && csr_ready) begin
         guard_hz_ff <= csr_guard_hz;
      end
   end

   // Gather the input fields.
   always_comb begin
      req_regs.modcfg_value          = req_modcfg_value;
      req_regs.modcfg_present        = req_modcfg_present;
      req_regs.rate_mantissa_value   = req_rate_mantissa_value;
      req_regs.rate_mantissa_present = req_rate_mantissa_present;
      req_regs.bw_exp_value          = req_bw_exp_value;
      req_regs.bw_exp_present        = req_bw_exp_present;
      req_regs.deviation_value       = req_deviation_value;
      req_regs.deviation_present     = req_deviation_present;
      req_regs.agc_value             = req_agc_value;
      req_regs.agc_present           = req_agc_present;
   end

   assign req_stall = !calc_in_ready;

   rfbs_freq_calc u_freq_calc (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (calc_in_ready),
      .in_regs   (req_regs),
      .out_valid (calc_valid),
      .out_ready (calc_ready),
      .out_freq  (calc_freq)
   );

   assign calc_ready = sel_in_ready;

   rfbs_bw_select u_bw_select (
      .clock      (clock),
      .reset      (reset),
      .guard_hz   (guard_hz_ff),
      .in_valid   (calc_valid),
      .in_ready   (sel_in_ready),
      .in_freq    (calc_freq),
      .out_valid  (rsp_valid),
      .out_ready  (!rsp_stall),
      .out_result (sel_result)
   );

   // Result fields.
   assign rsp_action       = sel_result.action;
   assign rsp_new_bw_exp   = sel_result.new_bw_exp;
   assign rsp_new_agc      = sel_result.new_agc;
   assign rsp_agc_changed  = sel_result.agc_changed;
   assign rsp_bandwidth_hz = sel_result.bandwidth_hz;

   // An OOK result always carries the fixed OOK filter setting.
   a_ook_setting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action == ACT_OOK |->
         rsp_new_bw_exp[7:4] == OOK_BW_CODE && rsp_bandwidth_hz == chan_bw(OOK_BW_CODE))
      else $error("rx_filter_bandwidth_selector_core: bad OOK setting");

   // The AGC patch only comes with a narrowed filter at or below the limit.
   a_agc_patch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_agc_changed |->
         rsp_action == ACT_FM_NARROWED && rsp_bandwidth_hz <= AGC_NARROW_LIMIT
         && rsp_new_agc[2:0] == AGC_NARROW_LOW)
      else $error("rx_filter_bandwidth_selector_core: unexpected AGC patch");

   // An FM result reports the bandwidth of its reported setting.
   a_bw_matches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_action == ACT_FM_OK || rsp_action == ACT_FM_NARROWED) |->
         rsp_bandwidth_hz == chan_bw(rsp_new_bw_exp[7:4]))
      else $error("rx_filter_bandwidth_selector_core: bandwidth mismatch");

endmodule

// ===== tb/sv/rx_filter_bandwidth_selector_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the receive filter bandwidth selector. It predicts
// every result item on its own and compares it with the block's output.
// Depends on rfbs_pkg and rx_filter_bandwidth_selector_core.
module rx_filter_bandwidth_selector_core_test;
   import rfbs_pkg::*;

   localparam logic [4:0]  AllPresent = 5'b11111;
   localparam int unsigned DrainLimit = 5000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_modcfg_value = '0;
   logic        req_modcfg_present = 1'b0;
   logic [7:0]  req_rate_mantissa_value = '0;
   logic        req_rate_mantissa_present = 1'b0;
   logic [7:0]  req_bw_exp_value = '0;
   logic        req_bw_exp_present = 1'b0;
   logic [7:0]  req_deviation_value = '0;
   logic        req_deviation_present = 1'b0;
   logic [7:0]  req_agc_value = '0;
   logic        req_agc_present = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_action;
   logic [7:0]  rsp_new_bw_exp;
   logic [7:0]  rsp_new_agc;
   logic        rsp_agc_changed;
   logic [19:0] rsp_bandwidth_hz;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [19:0] csr_guard_hz = '0;

   // Local copy of the guard margin, expected results and the error count.
   logic [GuardW-1:0] guard_margin_hz = GUARD_RESET;
   result_type        expected_selections[$];
   int unsigned       failures = 0;
   bit                req_gap_en = 1'b1;
   bit                rsp_stall_en = 1'b1;

   rx_filter_bandwidth_selector_core DUT (
      .clock                     (clock),
      .reset                     (reset),
      .req_valid                 (req_valid),
      .req_stall                 (req_stall),
      .req_modcfg_value          (req_modcfg_value),
      .req_modcfg_present        (req_modcfg_present),
      .req_rate_mantissa_value   (req_rate_mantissa_value),
      .req_rate_mantissa_present (req_rate_mantissa_present),
      .req_bw_exp_value          (req_bw_exp_value),
      .req_bw_exp_present        (req_bw_exp_present),
      .req_deviation_value       (req_deviation_value),
      .req_deviation_present     (req_deviation_present),
      .req_agc_value             (req_agc_value),
      .req_agc_present           (req_agc_present),
      .rsp_valid                 (rsp_valid),
      .rsp_stall                 (rsp_stall),
      .rsp_action                (rsp_action),
      .rsp_new_bw_exp            (rsp_new_bw_exp),
      .rsp_new_agc               (rsp_new_agc),
      .rsp_agc_changed           (rsp_agc_changed),
      .rsp_bandwidth_hz          (rsp_bandwidth_hz),
      .csr_valid                 (csr_valid),
      .csr_ready                 (csr_ready),
      .csr_guard_hz              (csr_guard_hz)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Channel filter bandwidth of a bandwidth code: crystal / (8 * (4 + M) * 2^E).
   function automatic logic [BwHzW-1:0] filter_hz(input logic [3:0] code);
      int unsigned divisor;
      divisor = (8 * (4 + code[1:0])) << code[3:2];
      return BwHzW'(XtalHz / divisor);
   endfunction

   // Expected result of one register set under the given guard margin.
   function automatic result_type predict_selection(input regs_type r,
                                                    input logic [GuardW-1:0] guard);
      result_type        res;
      longint unsigned   base;
      longint unsigned   rate;
      longint unsigned   dev;
      longint unsigned   need;
      logic [BwHzW-1:0]  pick_hz;
      logic [BwHzW-1:0]  orig_hz;
      logic [3:0]        pick_code;
      logic [2:0]        fmt;
      res.action       = ACT_RETAIN;
      res.new_bw_exp   = r.bw_exp_value;
      res.new_agc      = r.agc_value;
      res.agc_changed  = 1'b0;
      res.bandwidth_hz = r.bw_exp_present ? filter_hz(r.bw_exp_value[7:4]) : '0;
      fmt = r.modcfg_value[6:4];
      if (r.modcfg_present && fmt == MOD_OOK && r.bw_exp_present) begin
         res.action       = ACT_OOK;
         res.new_bw_exp   = {OOK_BW_CODE, r.bw_exp_value[3:0]};
         res.bandwidth_hz = filter_hz(OOK_BW_CODE);
      end else if (r.modcfg_present && (fmt == MOD_2FSK || fmt == MOD_GFSK) &&
                   r.rate_mantissa_present && r.bw_exp_present &&
                   r.deviation_present) begin
         // Data rate and deviation, both rounded to the nearest Hz.
         base = 64'(256 + r.rate_mantissa_value);
         rate = ((base << r.bw_exp_value[3:0]) * XtalHz + 64'h800_0000) >> 28;
         base = 64'(8 + r.deviation_value[2:0]);
         dev  = (((base * XtalHz) << r.deviation_value[6:4]) + 64'h1_0000) >> 17;
         need = rate + 2 * dev + guard;
         // Narrowest setting that still meets the need; widest if none does.
         pick_code = 4'd0;
         pick_hz   = filter_hz(4'd0);
         for (int i = 0; i < 16; i++) begin
            if (filter_hz(4'(i)) >= need) begin
               pick_code = 4'(i);
               pick_hz   = filter_hz(4'(i));
            end
         end
         orig_hz = filter_hz(r.bw_exp_value[7:4]);
         if (pick_hz >= orig_hz) begin
            res.action       = ACT_FM_OK;
            res.bandwidth_hz = orig_hz;
         end else begin
            res.action       = ACT_FM_NARROWED;
            res.new_bw_exp   = {pick_code, r.bw_exp_value[3:0]};
            res.bandwidth_hz = pick_hz;
            if (pick_hz <= AGC_NARROW_LIMIT && r.agc_present) begin
               res.new_agc     = {r.agc_value[7:3], AGC_NARROW_LOW};
               res.agc_changed = 1'b1;
            end
         end
      end
      return res;
   endfunction

   // Gap or stall length: mostly short, now and then long.
   function automatic int unsigned random_len();
      if ($urandom_range(0, 9) == 0)
         return $urandom_range(10, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic regs_type preset_item(input logic [7:0] modcfg,
                                            input logic [7:0] mant,
                                            input logic [7:0] bw,
                                            input logic [7:0] dev,
                                            input logic [7:0] agc,
                                            input logic [4:0] present);
      regs_type r;
      r.modcfg_value          = modcfg;
      r.modcfg_present        = present[4];
      r.rate_mantissa_value   = mant;
      r.rate_mantissa_present = present[3];
      r.bw_exp_value          = bw;
      r.bw_exp_present        = present[2];
      r.deviation_value       = dev;
      r.deviation_present     = present[1];
      r.agc_value             = agc;
      r.agc_present           = present[0];
      return r;
   endfunction

   // Mostly complete FM register sets, some OOK sets, the rest raw noise.
   function automatic regs_type random_regs();
      regs_type    r;
      logic [63:0] bits;
      int unsigned shape;
      bits  = {$urandom, $urandom};
      r     = bits[$bits(regs_type)-1:0];
      shape = $urandom_range(0, 99);
      if (shape < 65) begin
         r.modcfg_present        = 1'b1;
         r.modcfg_value[6:4]     = $urandom_range(0, 1) ? MOD_GFSK : MOD_2FSK;
         r.rate_mantissa_present = 1'b1;
         r.bw_exp_present        = 1'b1;
         r.deviation_present     = 1'b1;
         r.agc_present           = ($urandom_range(0, 4) != 0);
         // Low exponents keep the need small enough to narrow the filter.
         if ($urandom_range(0, 1)) begin
            r.bw_exp_value[3:0]    = 4'($urandom_range(0, 9));
            r.deviation_value[6:4] = 3'($urandom_range(0, 5));
         end
      end else if (shape < 80) begin
         r.modcfg_present    = 1'b1;
         r.modcfg_value[6:4] = MOD_OOK;
         r.bw_exp_present    = ($urandom_range(0, 7) != 0);
      end
      return r;
   endfunction

   // Offers one item, records its expected result on acceptance, then
   // possibly idles before the next one.
   task automatic send_item(input regs_type item);
      req_modcfg_value          <= item.modcfg_value;
      req_modcfg_present        <= item.modcfg_present;
      req_rate_mantissa_value   <= item.rate_mantissa_value;
      req_rate_mantissa_present <= item.rate_mantissa_present;
      req_bw_exp_value          <= item.bw_exp_value;
      req_bw_exp_present        <= item.bw_exp_present;
      req_deviation_value       <= item.deviation_value;
      req_deviation_present     <= item.deviation_present;
      req_agc_value             <= item.agc_value;
      req_agc_present           <= item.agc_present;
      req_valid                 <= 1'b1;
      do @(posedge clock); while (req_stall);
      expected_selections.push_back(predict_selection(item, guard_margin_hz));
      if (req_gap_en && $urandom_range(0, 1) == 0) begin
         req_valid <= 1'b0;
         repeat (random_len()) @(posedge clock);
      end
   endtask

   // Stops sending and waits until every expected result item has arrived.
   task automatic drain_results();
      int unsigned waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (expected_selections.size() != 0 && waited < DrainLimit);
      if (expected_selections.size() != 0) begin
         $error("%0d result items never arrived", expected_selections.size());
         failures++;
         expected_selections.delete();
      end
   endtask

   // Writes the guard margin; only called while nothing is in flight.
   task automatic write_guard(input logic [GuardW-1:0] value);
      csr_guard_hz <= value;
      csr_valid    <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      guard_margin_hz = value;
      csr_valid <= 1'b0;
   endtask

   task automatic check_field(input string name, input longint unsigned want,
                              input longint unsigned got);
      if (want !== got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         failures++;
      end
   endtask

   // Compares each accepted result item with the oldest expectation.
   always @(posedge clock) begin : check_results
      result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_selections.size() == 0) begin
            $error("result item with no expectation waiting");
            failures++;
         end else begin
            want = expected_selections.pop_front();
            check_field("action", want.action, rsp_action);
            check_field("new_bw_exp", want.new_bw_exp, rsp_new_bw_exp);
            check_field("new_agc", want.new_agc, rsp_new_agc);
            check_field("agc_changed", want.agc_changed, rsp_agc_changed);
            check_field("bandwidth_hz", want.bandwidth_hz, rsp_bandwidth_hz);
         end
      end
   end

   // Receiver back-pressure in random stretches.
   initial begin : rsp_backpressure
      int unsigned len;
      forever begin
         if (rsp_stall_en && $urandom_range(0, 2) == 0) begin
            len = random_len();
            rsp_stall <= 1'b1;
         end else begin
            len = $urandom_range(1, 8);
            rsp_stall <= 1'b0;
         end
         repeat (len) @(posedge clock);
      end
   end

   // Every decode path and boundary, under the reset guard margin.
   task automatic test_directed_cases();
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'b00000));
      send_item(preset_item(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, AllPresent));
      // Modulation config absent, and formats that are neither FM nor OOK.
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 5'b01111));
      send_item(preset_item(8'h20, 8'h00, 8'h00, 8'h00, 8'h00, AllPresent));
      send_item(preset_item(8'h40, 8'h00, 8'h00, 8'h00, 8'h00, AllPresent));
      // FM with rate, bandwidth or deviation register absent.
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 5'b10111));
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 5'b11011));
      send_item(preset_item(8'h10, 8'h00, 8'h00, 8'h00, 8'hFF, 5'b11101));
      // OOK without and with the bandwidth register.
      send_item(preset_item(8'h30, 8'h00, 8'h55, 8'h00, 8'hFF, 5'b11011));
      send_item(preset_item(8'hB0, 8'h12, 8'h07, 8'h00, 8'hFF, AllPresent));
      // Need above the widest setting: widest chosen, original kept.
      send_item(preset_item(8'h00, 8'hFF, 8'hFF, 8'h77, 8'h00, AllPresent));
      send_item(preset_item(8'h10, 8'hFF, 8'h0F, 8'h77, 8'h00, AllPresent));
      // Narrowed to the narrowest setting, AGC patched or absent.
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, AllPresent));
      send_item(preset_item(8'h10, 8'h00, 8'h00, 8'h00, 8'hFF, 5'b11110));
      // Narrowed exactly to the AGC limit, and to a setting above it.
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h34, 8'h00, AllPresent));
      send_item(preset_item(8'h00, 8'h00, 8'h00, 8'h43, 8'h07, AllPresent));
      // Bits outside the format field are ignored.
      send_item(preset_item(8'h8F, 8'h80, 8'h20, 8'hF8, 8'hAA, AllPresent));
      send_item(preset_item(8'h01, 8'hFF, 8'h10, 8'h77, 8'h00, AllPresent));
      drain_results();
   endtask

   // Guard margin extremes and a few values between them.
   task automatic test_guard_register();
      logic [GuardW-1:0] settings[5];
      settings = '{20'd0, 20'hFFFFF, 20'd1000000, 20'd1, 20'd0};
      settings[4] = GuardW'($urandom_range(0, 200000));
      foreach (settings[s]) begin
         write_guard(settings[s]);
         repeat (40) send_item(random_regs());
         drain_results();
      end
   endtask

   // Long random run in phases with their own guard margin and idling mix.
   task automatic test_random_traffic();
      logic [GuardW-1:0] guard;
      for (int phase = 0; phase < 6; phase++) begin
         if ($urandom_range(0, 3) == 0)
            guard = GuardW'($urandom_range(0, 20'hFFFFF));
         else
            guard = GuardW'($urandom_range(0, 150000));
         write_guard(guard);
         req_gap_en   = (phase != 2 && phase != 3);
         rsp_stall_en = (phase != 2 && phase != 4);
         for (int n = 0; n < 280; n++) begin
            send_item(random_regs());
            // Occasionally the sender holds off until the pipeline is empty.
            if ($urandom_range(0, 99) == 0)
               drain_results();
         end
         drain_results();
      end
      req_gap_en   = 1'b1;
      rsp_stall_en = 1'b1;
   endtask

   initial begin
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_guard_register();
      test_random_traffic();
      drain_results();
      repeat (20) @(posedge clock);
      if (failures == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // Run-away guard.
   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
